@@ hdl/brc_pkg.sv @@
// Shared types, widths and helpers for the barometer reading compensation block.
// Used by every module in hdl/; depends on nothing.

package brc_pkg;

  localparam int RawW  = 16;
  localparam int DtW   = 17;
  localparam int QW    = 10;
  localparam int QqW   = 20;
  localparam int KW    = 9;
  localparam int CorrW = 28;
  localparam int DutW  = 28;
  localparam int ProdW = 45;
  localparam int OffW  = 34;
  localparam int SensW = 35;
  localparam int TempW = 30;
  localparam int D1mW  = 17;
  localparam int XpW   = 52;
  localparam int XW    = 39;
  localparam int PresW = 44;
  localparam int OutW  = 16;
  localparam int DataW = 32;
  localparam int IdxW  = 3;

  localparam logic signed [DtW-1:0]   OffTcBase = 17'sd1024;
  localparam logic signed [D1mW-1:0]  PresBase  = 17'sd7168;
  localparam logic signed [ProdW-1:0] TempBase  = 45'sd250;

  typedef enum logic [IdxW-1:0] {
    REG_C1     = 3'd0,
    REG_C2     = 3'd1,
    REG_C3     = 3'd2,
    REG_C4     = 3'd3,
    REG_C5     = 3'd4,
    REG_C6     = 3'd5,
    REG_C7     = 3'd6,
    REG_SECOND = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RawW-1:0] c1;
    logic [RawW-1:0] c2;
    logic [RawW-1:0] c3;
    logic [RawW-1:0] c4;
    logic [RawW-1:0] c5;
    logic [RawW-1:0] c6;
    logic [RawW-1:0] c7;
    logic [7:0]      fa;
    logic [7:0]      fb;
    logic [7:0]      sc;
    logic [7:0]      sd;
  } cfg_t;

  typedef struct packed {
    logic signed [DutW-1:0] dut;
    logic [RawW-1:0]        d1;
  } mid_t;

  function automatic logic signed [OutW-1:0] sat16(input logic signed [PresW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > 44'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -44'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/brc_if.sv @@
// Valid/ready channel interfaces for the raw readings and the compensated results.
// Depends on brc_pkg for the field widths.

interface brc_in_if;
  logic                        valid;
  logic                        ready;
  logic [brc_pkg::RawW-1:0]    pressure_count;
  logic [brc_pkg::RawW-1:0]    temperature_count;

  modport source (output valid, output pressure_count, output temperature_count,
                  input ready);
  modport sink   (input valid, input pressure_count, input temperature_count,
                  output ready);
endinterface

interface brc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [brc_pkg::OutW-1:0]  pressure_tenths;
  logic signed [brc_pkg::OutW-1:0]  temperature_tenths;

  modport source (output valid, output pressure_tenths, output temperature_tenths,
                  input ready);
  modport sink   (input valid, input pressure_tenths, input temperature_tenths,
                  output ready);
endinterface

@@ hdl/brc_cfg.sv @@
// Calibration and second-order configuration registers with a plain write port.
// Depends on brc_pkg.

module brc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [brc_pkg::IdxW-1:0]     cfg_index,
  input  logic [brc_pkg::DataW-1:0]    cfg_data,
  output brc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (brc_pkg::reg_idx_t'(cfg_index))
        brc_pkg::REG_C1: begin
          cfg.c1 <= cfg_data[15:0];
        end
        brc_pkg::REG_C2: begin
          cfg.c2 <= cfg_data[15:0];
        end
        brc_pkg::REG_C3: begin
          cfg.c3 <= cfg_data[15:0];
        end
        brc_pkg::REG_C4: begin
          cfg.c4 <= cfg_data[15:0];
        end
        brc_pkg::REG_C5: begin
          cfg.c5 <= cfg_data[15:0];
        end
        brc_pkg::REG_C6: begin
          cfg.c6 <= cfg_data[15:0];
        end
        brc_pkg::REG_C7: begin
          cfg.c7 <= cfg_data[15:0];
        end
        brc_pkg::REG_SECOND: begin
          cfg.fa <= cfg_data[7:0];
          cfg.fb <= cfg_data[15:8];
          cfg.sc <= cfg_data[23:16];
          cfg.sd <= cfg_data[31:24];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

endmodule

@@ hdl/brc_front.sv @@
// Stages one to four: temperature difference and its second-order correction (dUT).
// Depends on brc_pkg.

module brc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  brc_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [brc_pkg::RawW-1:0]  pressure_count,
  input  logic [brc_pkg::RawW-1:0]  temperature_count,
  output logic                      mid_valid,
  input  logic                      mid_ready,
  output brc_pkg::mid_t             mid
);

  logic [3:0] vld;
  logic [3:0] adv;

  logic signed [brc_pkg::DtW-1:0]   dt1, dt2, dt3;
  logic [brc_pkg::RawW-1:0]         d1_1, d1_2, d1_3;
  logic signed [brc_pkg::QqW-1:0]   qq2;
  logic signed [brc_pkg::CorrW-1:0] corr3;

  logic signed [brc_pkg::DtW-1:0]   dt_next;
  logic signed [brc_pkg::QW-1:0]    q;
  logic signed [brc_pkg::QqW-1:0]   qq_next;
  logic signed [brc_pkg::KW-1:0]    kfac;
  logic signed [brc_pkg::CorrW-1:0] corr_next;
  logic signed [brc_pkg::CorrW-1:0] corr_sh;
  logic signed [brc_pkg::DutW-1:0]  dut_next;

  // A stage loads when it is empty or its word moves on in the same cycle.
  always_comb begin
    adv[3] = !vld[3] || mid_ready;
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign mid_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  assign dt_next   = $signed({1'b0, temperature_count}) - $signed({1'b0, cfg.c5});
  assign q         = dt1[brc_pkg::DtW-1:7];
  assign qq_next   = q * q;
  assign kfac      = dt2[brc_pkg::DtW-1] ? $signed({1'b0, cfg.fb}) : $signed({1'b0, cfg.fa});
  assign corr_next = qq2 * kfac;
  // The correction is never negative, so a shift beyond its width leaves zero.
  assign corr_sh   = corr3 >>> cfg.sc;
  assign dut_next  = dt3 - corr_sh;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt1  <= dt_next;
      d1_1 <= pressure_count;
    end
    if (adv[1]) begin
      qq2  <= qq_next;
      dt2  <= dt1;
      d1_2 <= d1_1;
    end
    if (adv[2]) begin
      corr3 <= corr_next;
      dt3   <= dt2;
      d1_3  <= d1_2;
    end
    if (adv[3]) begin
      mid.dut <= dut_next;
      mid.d1  <= d1_3;
    end
  end

endmodule

@@ hdl/brc_back.sv @@
// Stages five to nine: offset, sensitivity, pressure, temperature and saturation.
// Depends on brc_pkg; the last stage is the output register.

module brc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  brc_pkg::cfg_t                    cfg,
  input  logic                             mid_valid,
  output logic                             mid_ready,
  input  brc_pkg::mid_t                    mid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [brc_pkg::OutW-1:0]  pressure_tenths,
  output logic signed [brc_pkg::OutW-1:0]  temperature_tenths
);

  logic [4:0] vld;
  logic [4:0] adv;

  logic signed [brc_pkg::ProdW-1:0] offp5, sensp5, tempp5;
  logic signed [brc_pkg::DutW-1:0]  dut5;
  logic [brc_pkg::RawW-1:0]         d1_5;
  logic signed [brc_pkg::OffW-1:0]  off6, off7;
  logic signed [brc_pkg::SensW-1:0] sens6;
  logic signed [brc_pkg::TempW-1:0] temp6, temp7;
  logic signed [brc_pkg::D1mW-1:0]  d1m6;
  logic signed [brc_pkg::XpW-1:0]   xp7;
  logic signed [brc_pkg::XW-1:0]    x8;
  logic signed [brc_pkg::OutW-1:0]  temp8;

  logic signed [brc_pkg::DtW-1:0]   c4m;
  logic signed [brc_pkg::ProdW-1:0] offp_next, sensp_next, tempp_next;
  logic signed [brc_pkg::ProdW-1:0] off_sum, sens_sum, temp_sum;
  logic signed [brc_pkg::D1mW-1:0]  d1m_next;
  logic signed [brc_pkg::XpW-1:0]   xp_next;
  logic signed [brc_pkg::XpW-1:0]   x_sum;
  logic signed [brc_pkg::PresW-1:0] pres_sum;

  always_comb begin
    adv[4] = !vld[4] || out_ready;
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign mid_ready = adv[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= mid_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
    end
  end

  assign c4m        = $signed({1'b0, cfg.c4}) - brc_pkg::OffTcBase;
  assign offp_next  = c4m * mid.dut;
  assign sensp_next = $signed({1'b0, cfg.c3}) * mid.dut;
  assign tempp_next = $signed({1'b0, cfg.c6}) * mid.dut;

  assign off_sum  = (offp5 >>> 14) + $signed({1'b0, cfg.c2});
  assign sens_sum = (sensp5 >>> 10) + $signed({1'b0, cfg.c1});
  // A shift by D beyond the width of dUT leaves only its sign, as intended.
  assign temp_sum = (tempp5 >>> 16) - (dut5 >>> cfg.sd) + brc_pkg::TempBase;
  assign d1m_next = $signed({1'b0, d1_5}) - brc_pkg::PresBase;

  assign xp_next  = d1m6 * sens6;
  assign x_sum    = (xp7 >>> 14) - off7;

  // Times ten as two shifted copies added together.
  assign pres_sum = (((x8 <<< 3) + (x8 <<< 1)) >>> 5) + $signed({1'b0, cfg.c7});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      offp5  <= offp_next;
      sensp5 <= sensp_next;
      tempp5 <= tempp_next;
      dut5   <= mid.dut;
      d1_5   <= mid.d1;
    end
    if (adv[1]) begin
      off6  <= $signed({off_sum[31:0], 2'b00});
      sens6 <= sens_sum[brc_pkg::SensW-1:0];
      temp6 <= temp_sum[brc_pkg::TempW-1:0];
      d1m6  <= d1m_next;
    end
    if (adv[2]) begin
      xp7   <= xp_next;
      off7  <= off6;
      temp7 <= temp6;
    end
    if (adv[3]) begin
      x8    <= x_sum[brc_pkg::XW-1:0];
      temp8 <= brc_pkg::sat16(brc_pkg::PresW'(temp7));
    end
    if (adv[4]) begin
      pressure_tenths    <= brc_pkg::sat16(pres_sum);
      temperature_tenths <= temp8;
    end
  end

endmodule

@@ hdl/barometer_reading_compensation.sv @@
// Top level of the barometer reading compensation block.
// Depends on brc_pkg, brc_if, brc_cfg, brc_front and brc_back.
//
//   channel   direction  word
//   sample    in         pressure_count, temperature_count (16 bit unsigned)
//   result    out        pressure_tenths, temperature_tenths (16 bit signed)
//   cfg       in         cfg_we, cfg_index (3 bit), cfg_data (32 bit), no wait
//
// One word is accepted per cycle unless a stalled result has filled every stage; each result
// passes through the nine-stage multiply chain (four stages for dUT, five for the rest).
// Reset is synchronous and empties every stage; configuration resets to zero.
// A stalled result holds the last stage while the stages behind it keep filling
// bubbles; sample.ready falls only once every stage holds a word.

module barometer_reading_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [brc_pkg::IdxW-1:0]   cfg_index,
  input  logic [brc_pkg::DataW-1:0]  cfg_data,
  brc_in_if.sink                     sample,
  brc_out_if.source                  result
);

  brc_pkg::cfg_t cfg;
  brc_pkg::mid_t mid;
  logic          mid_valid;
  logic          mid_ready;

  brc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (sample.valid),
    .in_ready          (sample.ready),
    .pressure_count    (sample.pressure_count),
    .temperature_count (sample.temperature_count),
    .mid_valid         (mid_valid),
    .mid_ready         (mid_ready),
    .mid               (mid)
  );

  brc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .mid_valid          (mid_valid),
    .mid_ready          (mid_ready),
    .mid                (mid),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .pressure_tenths    (result.pressure_tenths),
    .temperature_tenths (result.temperature_tenths)
  );

endmodule

@@ hdl/brc_checker.sv @@
// Port-level checks for barometer_reading_compensation and the bind that attaches them.
// Depends on brc_pkg and the top level's ports only.

module brc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [brc_pkg::OutW-1:0]  pressure_tenths,
  input logic signed [brc_pkg::OutW-1:0]  temperature_tenths
);

  logic [3:0] in_flight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 4'(in_acc) - 4'(out_acc);
    end
  end

  // The pipeline never holds more words than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst) in_flight <= 4'd9)
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 4'd0)
    else $error("result shown with no word in flight");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    in_flight == 4'd0 |-> in_ready)
    else $error("empty pipeline refuses a word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_tenths)
                                && $stable(temperature_tenths))
    else $error("stalled result changed");

endmodule

bind barometer_reading_compensation brc_checker u_brc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (sample.valid),
  .in_ready           (sample.ready),
  .out_valid          (result.valid),
  .out_ready          (result.ready),
  .pressure_tenths    (result.pressure_tenths),
  .temperature_tenths (result.temperature_tenths)
);
